@@ design/tmc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, register codes and constants of the HDR tone-mapping block.
// ----------------------------------------------------------------------------
package tmc_pkg;

  // channel and port widths
  localparam int CHW       = 24;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int NITS_W    = 14;

  // default fraction bits and extra quotient bits of the filmic curve
  localparam int FRAC_BITS_DEF = 16;
  localparam int HABLE_EXTRA   = 8;

  // filmic white-point normalisation, value at 11.2 is HABLE_DEN / HABLE_NUM
  localparam int HABLE_NUM = 91785;
  localparam int HABLE_DEN = 66556;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NITS = 2'd2;

  // curve modes
  localparam logic [MODE_W-1:0] MODE_PASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACES  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HABLE = 2'd3;

  typedef struct packed {
    logic [CHW-1:0] red_in;
    logic [CHW-1:0] green_in;
    logic [CHW-1:0] blue_in;
  } tmc_pix_t;

  typedef struct packed {
    logic [CHW-1:0] red_out;
    logic [CHW-1:0] green_out;
    logic [CHW-1:0] blue_out;
  } tmc_res_t;

  // side data that travels with a channel down the lane
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHW-1:0]    raw;
    logic              sat;
  } tmc_tag_t;

  // edges from an accepted beat to the edge that samples its result strobe
  function automatic int tmc_latency(input int fb);
    return fb + HABLE_EXTRA + 10;
  endfunction

endpackage

@@ design/tmc_div_step.sv @@
// ----------------------------------------------------------------------------
// tmc_div_step
// One registered step of the restoring long division: one quotient bit.
// ----------------------------------------------------------------------------
module tmc_div_step #(
  parameter int NDW = 58,
  parameter int QW  = 25
) (
  input  logic              clk_i,
  input  logic [NDW-1:0]    r_i,
  input  logic [NDW-1:0]    d_i,
  input  logic [QW-1:0]     q_i,
  input  tmc_pkg::tmc_tag_t tag_i,
  output logic [NDW-1:0]    r_o,
  output logic [NDW-1:0]    d_o,
  output logic [QW-1:0]     q_o,
  output tmc_pkg::tmc_tag_t tag_o
);
  import tmc_pkg::*;

  logic [NDW:0]   rs;
  logic [NDW:0]   rn;
  logic           ge;
  logic [NDW-1:0] r_d;
  logic [QW-1:0]  q_d;

  // shift in a zero, trial subtract
  always_comb begin
    rs  = {r_i, 1'b0};
    ge  = rs >= {1'b0, d_i};
    rn  = ge ? (rs - {1'b0, d_i}) : rs;
    r_d = rn[NDW-1:0];
    q_d = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    r_o   <= r_d;
    d_o   <= d_i;
    q_o   <= q_d;
    tag_o <= tag_i;
  end

endmodule

@@ design/tmc_lane.sv @@
// ----------------------------------------------------------------------------
// tmc_lane
// One colour channel: exposure, clamp, curve terms, pipelined division and
// filmic normalisation, one channel value per cycle.
// ----------------------------------------------------------------------------
module tmc_lane #(
  parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic [tmc_pkg::MODE_W-1:0]  mode_i,
  input  logic [tmc_pkg::CHW-1:0]     gain_i,
  input  logic [tmc_pkg::CHW-1:0]     maxfix_i,
  input  logic [tmc_pkg::CHW-1:0]     ch_i,
  output logic [tmc_pkg::CHW-1:0]     ch_o
);
  import tmc_pkg::*;

  localparam int B    = FRAC_BITS + HABLE_EXTRA;
  localparam int QW   = B + 1;
  localparam int NDW  = 2 * CHW + 10;
  localparam int NW   = QW + 17;
  localparam int MW   = NW - 8;
  localparam int RW   = MW - 16;
  localparam int MLO  = MW / 2;
  localparam int MHI  = MW - MLO;
  localparam int SW   = FRAC_BITS + 1;
  localparam longint unsigned RECIP = (64'd1 << MW) / 64'd66556;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [SW-1:0] ONE_S   = SW'(1) << FRAC_BITS;
  localparam logic [RW:0]   ONE_Y   = (RW + 1)'(1) << FRAC_BITS;

  // stage 1: gain product
  logic [2*CHW-1:0] prod_q;
  tmc_tag_t         tag1_q;

  always_ff @(posedge clk_i) begin
    prod_q      <= (2*CHW)'(ch_i) * (2*CHW)'(gain_i);
    tag1_q.mode <= mode_i;
    tag1_q.raw  <= ch_i;
    tag1_q.sat  <= 1'b0;
  end

  // stage 2: shift, saturate, clamp to display ceiling
  logic [2*CHW-1:0] sh;
  logic [CHW-1:0]   xs;
  logic [CHW-1:0]   x_d;
  logic [CHW-1:0]   x_q;
  tmc_tag_t         tag2_q;

  always_comb begin
    sh  = prod_q >> FRAC_BITS;
    xs  = (|sh[2*CHW-1:CHW]) ? {CHW{1'b1}} : sh[CHW-1:0];
    x_d = (xs > maxfix_i) ? maxfix_i : xs;
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    tag2_q <= tag1_q;
  end

  // stage 3: square
  logic [2*CHW-1:0] x2_q;
  logic [CHW-1:0]   x3_q;
  tmc_tag_t         tag3_q;

  always_ff @(posedge clk_i) begin
    x2_q   <= (2*CHW)'(x_q) * (2*CHW)'(x_q);
    x3_q   <= x_q;
    tag3_q <= tag2_q;
  end

  // stage 4: numerator and denominator of the selected curve
  logic [NDW-1:0] xe, x2e, xo, one_e, one2;
  logic [NDW-1:0] n_d, d_d, n_q, d_q;
  tmc_tag_t       tag4_q;

  always_comb begin
    xe    = NDW'(x3_q);
    x2e   = NDW'(x2_q);
    xo    = xe << FRAC_BITS;
    one_e = NDW'(1) << FRAC_BITS;
    one2  = NDW'(1) << (2 * FRAC_BITS);
    case (tag3_q.mode)
      MODE_REIN: begin
        n_d = xe;
        d_d = one_e + xe;
      end
      MODE_ACES: begin
        n_d = NDW'(251) * x2e + NDW'(3) * xo;
        d_d = NDW'(243) * x2e + NDW'(59) * xo + NDW'(14) * one2;
      end
      default: begin
        n_d = NDW'(210) * x2e + NDW'(25) * xo;
        d_d = NDW'(225) * x2e + NDW'(750) * xo + NDW'(90) * one2;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    tag4_q <= tag3_q;
  end

  // division pipeline, one quotient bit per stage
  logic [NDW-1:0] r_s [QW+1];
  logic [NDW-1:0] d_s [QW+1];
  logic [QW-1:0]  q_s [QW+1];
  tmc_tag_t       tag_s [QW+1];

  always_comb begin
    r_s[0]         = n_q;
    d_s[0]         = d_q;
    q_s[0]         = '0;
    tag_s[0]       = tag4_q;
    tag_s[0].sat   = n_q >= d_q;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    tmc_div_step #(
      .NDW (NDW),
      .QW  (QW)
    ) u_step (
      .clk_i (clk_i),
      .r_i   (r_s[i]),
      .d_i   (d_s[i]),
      .q_i   (q_s[i]),
      .tag_i (tag_s[i]),
      .r_o   (r_s[i+1]),
      .d_o   (d_s[i+1]),
      .q_o   (q_s[i+1]),
      .tag_o (tag_s[i+1])
    );
  end

  // post a: rounding, filmic scale numerator
  logic [QW:0]    qf1;
  logic [QW-1:0]  h;
  logic [SW:0]    sm1;
  logic [SW-1:0]  sm;
  logic [NW-1:0]  nn;
  logic [MW-1:0]  m_a_q;
  logic [SW-1:0]  sm_a_q;
  tmc_tag_t       tag_a_q;

  always_comb begin
    qf1 = (QW + 1)'(q_s[QW]) + (QW + 1)'(1);
    sm1 = (SW + 1)'(q_s[QW] >> HABLE_EXTRA) + (SW + 1)'(1);
    if (tag_s[QW].sat) begin
      h  = QW'(1) << B;
      sm = ONE_S;
    end else begin
      h  = qf1[QW:1];
      sm = sm1[SW:1];
    end
    nn = NW'(h) * NW'(HABLE_NUM) + NW'(HABLE_DEN * 128);
  end

  always_ff @(posedge clk_i) begin
    m_a_q   <= nn[NW-1:8];
    sm_a_q  <= sm;
    tag_a_q <= tag_s[QW];
  end

  // post b: reciprocal partial products
  logic [MLO+RW-1:0] pl_q;
  logic [MHI+RW-1:0] ph_q;
  logic [MW-1:0]     m_b_q;
  logic [SW-1:0]     sm_b_q;
  tmc_tag_t          tag_b_q;

  always_ff @(posedge clk_i) begin
    pl_q    <= (MLO + RW)'(m_a_q[MLO-1:0]) * (MLO + RW)'(RECIP_V);
    ph_q    <= (MHI + RW)'(m_a_q[MW-1:MLO]) * (MHI + RW)'(RECIP_V);
    m_b_q   <= m_a_q;
    sm_b_q  <= sm_a_q;
    tag_b_q <= tag_a_q;
  end

  // post c: combine partial products into the quotient estimate
  logic [MW+RW-1:0] psum;
  logic [RW-1:0]    q0_q;
  logic [MW-1:0]    m_c_q;
  logic [SW-1:0]    sm_c_q;
  tmc_tag_t         tag_c_q;

  assign psum = ((MW + RW)'(ph_q) << MLO) + (MW + RW)'(pl_q);

  always_ff @(posedge clk_i) begin
    q0_q    <= psum[MW+RW-1:MW];
    m_c_q   <= m_b_q;
    sm_c_q  <= sm_b_q;
    tag_c_q <= tag_b_q;
  end

  // post d: correct estimate by one, clamp, pick output by mode
  logic [RW+16:0] qm;
  logic [MW-1:0]  rem;
  logic [RW:0]    y;
  logic [RW:0]    hv;
  logic [CHW-1:0] out_d;
  logic [CHW-1:0] out_q;

  always_comb begin
    qm  = (RW + 17)'(q0_q) * (RW + 17)'(HABLE_DEN);
    rem = m_c_q - MW'(qm);
    y   = (rem >= MW'(HABLE_DEN)) ? ((RW + 1)'(q0_q) + (RW + 1)'(1)) : (RW + 1)'(q0_q);
    hv  = (y > ONE_Y) ? ONE_Y : y;
    case (tag_c_q.mode)
      MODE_PASS:  out_d = tag_c_q.raw;
      MODE_HABLE: out_d = CHW'(hv);
      default:    out_d = CHW'(sm_c_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign ch_o = out_q;

endmodule

@@ design/hdr_tone_map_curves.sv @@
// ----------------------------------------------------------------------------
// hdr_tone_map_curves
// Per-pixel HDR tone mapping with three channel lanes and a merging register.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; busy_o stays low, the lanes are fully
//   pipelined and the long division takes FRAC_BITS + 9 stages of each lane.
// Reset: clears the result strobe pipeline and sets the registers to
//   passthrough, unit gain and 1000 nits; results cannot be held off.
module hdr_tone_map_curves #(
  parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  tmc_pkg::tmc_pix_t             pix_i,
  output logic                          done_o,
  output tmc_pkg::tmc_res_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [tmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tmc_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import tmc_pkg::*;

  localparam int LAT = tmc_latency(FRAC_BITS);
  localparam int K   = FRAC_BITS - 4;
  localparam logic [CHW-1:0] ONE_C = CHW'(1) << FRAC_BITS;
  localparam longint unsigned MF_RAW = (64'd1000 << FRAC_BITS) / 64'd80;
  localparam longint unsigned MF_SAT = (MF_RAW > 64'hFFFFFF) ? 64'hFFFFFF : MF_RAW;
  localparam logic [CHW-1:0] MF_RST =
      (MF_SAT < (64'd1 << FRAC_BITS)) ? ONE_C : CHW'(MF_SAT);
  localparam logic [39:0] FR1 = 40'((64'd1 << K) / 64'd5);
  localparam logic [39:0] FR2 = 40'((64'd2 << K) / 64'd5);
  localparam logic [39:0] FR3 = 40'((64'd3 << K) / 64'd5);
  localparam logic [39:0] FR4 = 40'((64'd4 << K) / 64'd5);

  logic [MODE_W-1:0] mode_q;
  logic [CHW-1:0]    gain_q;
  logic [CHW-1:0]    maxfix_q;
  logic [CHW-1:0]    maxfix_d;

  // display ceiling nits * ONE / 80, saturated and at least 1.0
  logic [NITS_W-1:0] nits;
  logic [27:0]       t5;
  logic [11:0]       q5;
  logic [NITS_W-1:0] r5w;
  logic [39:0]       frac;
  logic [39:0]       mf_full;

  always_comb begin
    nits    = cfg_wdata_i[NITS_W-1:0];
    t5      = 28'(nits) * 28'd13108;
    q5      = t5[27:16];
    r5w     = nits - NITS_W'(16'(q5) * 16'd5);
    case (r5w[2:0])
      3'd1:    frac = FR1;
      3'd2:    frac = FR2;
      3'd3:    frac = FR3;
      3'd4:    frac = FR4;
      default: frac = '0;
    endcase
    mf_full = (40'(q5) << K) + frac;
    if (|mf_full[39:CHW]) begin
      maxfix_d = {CHW{1'b1}};
    end else if (mf_full[CHW-1:0] < ONE_C) begin
      maxfix_d = ONE_C;
    end else begin
      maxfix_d = mf_full[CHW-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PASS;
      gain_q   <= ONE_C;
      maxfix_q <= MF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: mode_q   <= cfg_wdata_i[MODE_W-1:0];
        CFG_GAIN: gain_q   <= cfg_wdata_i[CHW-1:0];
        CFG_NITS: maxfix_q <= maxfix_d;
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // beat valid line alongside the lanes
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // channel lanes
  logic [CHW-1:0] red_l, green_l, blue_l;

  tmc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
    .clk_i    (clk_i),
    .mode_i   (mode_q),
    .gain_i   (gain_q),
    .maxfix_i (maxfix_q),
    .ch_i     (pix_i.red_in),
    .ch_o     (red_l)
  );

  tmc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g (
    .clk_i    (clk_i),
    .mode_i   (mode_q),
    .gain_i   (gain_q),
    .maxfix_i (maxfix_q),
    .ch_i     (pix_i.green_in),
    .ch_o     (green_l)
  );

  tmc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk_i    (clk_i),
    .mode_i   (mode_q),
    .gain_i   (gain_q),
    .maxfix_i (maxfix_q),
    .ch_i     (pix_i.blue_in),
    .ch_o     (blue_l)
  );

  // merge lanes into the result beat
  tmc_res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.red_out   <= red_l;
    res_q.green_out <= green_l;
    res_q.blue_out  <= blue_l;
  end

  assign res_o  = res_q;
  assign done_o = vld_q[LAT-1];

endmodule

@@ design/tmc_chk.sv @@
// ----------------------------------------------------------------------------
// tmc_chk
// Port-level checks of the tone mapper: timing of results, passthrough and curve ranges.
// ----------------------------------------------------------------------------
module tmc_chk #(
  parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input tmc_pkg::tmc_pix_t             pix_i,
  input logic                          done_o,
  input tmc_pkg::tmc_res_t             res_o,
  input logic                          cfg_we_i,
  input logic [tmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [tmc_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import tmc_pkg::*;

  localparam int LAT = tmc_latency(FRAC_BITS);
  localparam logic [CHW-1:0] ONE_C = CHW'(1) << FRAC_BITS;

  logic              acc;
  logic [MODE_W-1:0] mode_sh_q;

  assign acc = start_i && !busy_o;

  // shadow of the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_sh_q <= MODE_PASS;
    end else if (cfg_we_i && (cfg_idx_i == CFG_MODE)) begin
      mode_sh_q <= cfg_wdata_i[MODE_W-1:0];
    end
  end

  // every accepted beat gives one strobe, a fixed time later
  a_beat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o) else $error("result strobe missing");

  a_done_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT)) else $error("result strobe without beat");

  // passthrough returns the pixel unchanged
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(acc && (mode_sh_q == MODE_PASS), LAT)) |->
      ((res_o.red_out == $past(pix_i.red_in, LAT)) &&
       (res_o.green_out == $past(pix_i.green_in, LAT)) &&
       (res_o.blue_out == $past(pix_i.blue_in, LAT))))
    else $error("passthrough altered pixel");

  // curve modes stay within 0 to 1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(acc && (mode_sh_q != MODE_PASS), LAT)) |->
      ((res_o.red_out <= ONE_C) && (res_o.green_out <= ONE_C) &&
       (res_o.blue_out <= ONE_C)))
    else $error("curve result above 1.0");

endmodule

bind hdr_tone_map_curves tmc_chk #(.FRAC_BITS(FRAC_BITS)) u_tmc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .pix_i       (pix_i),
  .done_o      (done_o),
  .res_o       (res_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);

@@ sim/hdr_tone_map_curves_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdr_tone_map_curves_tb
// Drives pixels through every curve mode under several gain and peak-nits
// settings, predicts each mapped pixel in fixed point and checks every result.
// ----------------------------------------------------------------------------
module hdr_tone_map_curves_tb;
  import tmc_pkg::*;

  localparam int FB      = FRAC_BITS_DEF;
  localparam int LAT     = FB + HABLE_EXTRA + 10;
  localparam logic [63:0] ONE = 64'd1 << FB;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  tmc_pix_t             pix_i = '0;
  logic                 done_o;
  tmc_res_t             res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // predictor copy of the registers
  logic [MODE_W-1:0] mdl_mode;
  logic [CHW-1:0]    mdl_gain;
  logic [NITS_W-1:0] mdl_nits;

  tmc_res_t expected_pix_q[$];
  int       n_fail = 0;

  hdr_tone_map_curves #(.FRAC_BITS(FB)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  // rounded fraction n/d in the given bits, saturated at one
  function automatic logic [63:0] round_quot(input logic [63:0] n, input logic [63:0] d,
                                             input int bits);
    logic [63:0] r, q;
    r = n;
    q = 0;
    if (d == 0 || n >= d) return 64'd1 << bits;
    for (int i = 0; i <= bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic logic [CHW-1:0] tone_channel(input logic [CHW-1:0] c,
                                                  input logic [63:0] ceil_fx);
    logic [63:0] x, x2, h, dv, y;
    x = (64'(c) * 64'(mdl_gain)) >> FB;
    if (x > 64'hFFFFFF) x = 64'hFFFFFF;
    if (x > ceil_fx) x = ceil_fx;
    x2 = x * x;
    case (mdl_mode)
      MODE_REIN: return CHW'(round_quot(x, ONE + x, FB));
      MODE_ACES: return CHW'(round_quot(251 * x2 + 3 * x * ONE,
                                        243 * x2 + 59 * x * ONE + 14 * ONE * ONE, FB));
      default: begin
        h = round_quot(210 * x2 + 25 * x * ONE,
                       225 * x2 + 750 * x * ONE + 90 * ONE * ONE, FB + HABLE_EXTRA);
        dv = 64'(HABLE_DEN) << HABLE_EXTRA;
        y = (h * HABLE_NUM + dv / 2) / dv;
        if (y > ONE) y = ONE;
        return CHW'(y);
      end
    endcase
  endfunction

  function automatic tmc_res_t tone_map_pixel(input tmc_pix_t p);
    tmc_res_t r;
    logic [63:0] ceil_fx;
    if (mdl_mode == MODE_PASS) return {p.red_in, p.green_in, p.blue_in};
    ceil_fx = (64'(mdl_nits) * ONE) / 80;
    if (ceil_fx < ONE) ceil_fx = ONE;
    r.red_out   = tone_channel(p.red_in, ceil_fx);
    r.green_out = tone_channel(p.green_in, ceil_fx);
    r.blue_out  = tone_channel(p.blue_in, ceil_fx);
    return r;
  endfunction

  // result checker, strobe sampled at the edge
  always @(posedge clk_i) begin
    tmc_res_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_pix_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        n_fail++;
      end else begin
        exp_r = expected_pix_q.pop_front();
        if (res_o.red_out !== exp_r.red_out) begin
          $display("%0t: red exp %h got %h", $time, exp_r.red_out, res_o.red_out);
          n_fail++;
        end
        if (res_o.green_out !== exp_r.green_out) begin
          $display("%0t: green exp %h got %h", $time, exp_r.green_out, res_o.green_out);
          n_fail++;
        end
        if (res_o.blue_out !== exp_r.blue_out) begin
          $display("%0t: blue exp %h got %h", $time, exp_r.blue_out, res_o.blue_out);
          n_fail++;
        end
      end
    end
  end

  // wait until the pipeline is empty
  task automatic drain();
    while (expected_pix_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  // one register write, then the enable is dropped and the bus idles before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE: mdl_mode = val[MODE_W-1:0];
      CFG_GAIN: mdl_gain = val;
      CFG_NITS: mdl_nits = val[NITS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_curves(input logic [MODE_W-1:0] m, input logic [CHW-1:0] g,
                            input logic [CFG_W-1:0] nits);
    drain();
    write_reg(CFG_MODE, CFG_W'(m));
    write_reg(CFG_GAIN, g);
    write_reg(CFG_NITS, nits);
  endtask

  // send one pixel beat, optionally with a gap before it
  task automatic send_pixel(input tmc_pix_t p, input bit gap);
    int g;
    if (gap) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (g > 0) begin
        start_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    pix_i   <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_pix_q.push_back(tone_map_pixel(p));
  endtask

  task automatic end_burst();
    start_i <= 1'b0;
  endtask

  function automatic logic [CHW-1:0] rand_chan();
    case ($urandom_range(0, 4))
      0: return CHW'($urandom_range(0, 2 * ONE));
      1: return CHW'($urandom_range(0, 16 * ONE));
      2: return CHW'($urandom);
      3: return ($urandom_range(0, 1)) ? '1 : '0;
      default: return CHW'($urandom_range(0, ONE));
    endcase
  endfunction

  // field extremes across every mode
  task automatic test_directed();
    logic [CHW-1:0] v[5] = '{24'h0, 24'hFFFFFF, 24'h010000, 24'h0B3333, 24'hAAAAAA};
    for (int m = 0; m < 4; m++) begin
      set_curves(MODE_W'(m), 24'h010000, 24'd1000);
      for (int i = 0; i < 5; i++)
        send_pixel('{v[i], v[(i + 1) % 5], v[(i + 2) % 5]}, 1'b0);
      end_burst();
    end
  endtask

  // zero gain, zero nits, low nits, wide gain
  task automatic test_corner_regs();
    set_curves(MODE_REIN, 24'h0, 24'd0);
    send_pixel('{24'hFFFFFF, 24'h123456, 24'h010000}, 1'b0);
    end_burst();
    set_curves(MODE_ACES, 24'hFFFFFF, 24'd0);
    send_pixel('{24'hFFFFFF, 24'h000001, 24'h008000}, 1'b0);
    end_burst();
    set_curves(MODE_HABLE, 24'hFFFFFF, 24'd79);
    send_pixel('{24'hFFFFFF, 24'h000001, 24'h000100}, 1'b0);
    end_burst();
    set_curves(MODE_HABLE, 24'h010000, 24'h3FFF);
    send_pixel('{24'hFFFFFF, 24'h0B3333, 24'h500000}, 1'b0);
    end_burst();
    // index three is ignored; mode write with high bits set is masked
    drain();
    write_reg(2'd3, 24'hFFFFFF);
    write_reg(CFG_MODE, 24'hFFFFFD);
    write_reg(CFG_NITS, 24'hFFD000);
    send_pixel('{24'h020000, 24'h7FFFFF, 24'h000000}, 1'b0);
    end_burst();
  endtask

  // random pixels over a sweep of register settings
  task automatic test_random();
    logic [CHW-1:0] g;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: g = 24'h010000;
        1: g = CHW'($urandom_range(0, 8 * ONE));
        2: g = CHW'($urandom);
        default: g = CHW'($urandom_range(0, ONE));
      endcase
      set_curves(MODE_W'(ph % 4), g, CFG_W'($urandom_range(0, 10000)));
      for (int i = 0; i < 50; i++)
        send_pixel('{rand_chan(), rand_chan(), rand_chan()}, $urandom_range(0, 2) != 0);
      end_burst();
    end
  endtask

  initial begin
    mdl_mode = MODE_PASS;
    mdl_gain = CHW'(ONE);
    mdl_nits = 14'd1000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pixel('{24'hFFFFFF, 24'h000000, 24'h5A5A5A}, 1'b0);
    end_burst();
    test_directed();
    test_corner_regs();
    test_random();
    drain();
    if (n_fail == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
